>>> hdl/adaptive_periodic_task_scheduler_macros.svh
// assertion helpers used by the checker file
`ifndef ADAPTIVE_PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define ADAPTIVE_PERIODIC_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define APS_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define APS_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/aps_pkg.sv
package aps_pkg;

    // command codes
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_SCAN     = 2'd1;
    localparam logic [1:0] CMD_REPORT   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;
    localparam logic [1:0] KIND_REPORT   = 2'd3;

    // config space
    localparam int   APB_ADDR_W   = 3;
    localparam logic REG_ADAPTIVE = 1'b0;
    localparam logic REG_GUARD    = 1'b1;

    // tuning thresholds
    localparam int AVG_HIGH      = 800;
    localparam int AVG_LOW       = 150;
    localparam int PERIOD_FLOOR  = 10;
    localparam int PERIOD_GROW   = 5;
    localparam int FREE_MEM_MIN  = 200;
    localparam int AVG_KEEP      = 7;
    localparam int AVG_SHIFT     = 3;

    // load = sum / 10 via reciprocal multiply, exact below 2^22
    localparam int          LOAD_SAT_SUM = 655350;
    localparam int          LOAD_IN_W    = 20;
    localparam logic [19:0] RECIP_TEN    = 20'd838861;
    localparam int          RECIP_SHIFT  = 23;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now_ms;
        logic [31:0]        init_period;
        logic [3:0]         task_slot;
        logic [23:0]        runtime_us;
        logic signed [15:0] free_memory;
    } aps_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [3:0]  task_id;
        logic [31:0] current_period;
        logic [15:0] cpu_load;
        logic        last_result;
    } aps_out_t;

endpackage

>>> hdl/adaptive_periodic_task_scheduler.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------------
// item      | start & !busy                  | item   (aps_in_t)
// result    | result_valid, one cycle, final | result (aps_out_t)
// config    | psel & penable & pwrite        | paddr / pwdata, prdata
//
// a register command shows its result the next cycle; unused codes give none
// scan reads one table entry per cycle through the task memory read port, then
// drains the held dispatch in ST_SCAN_FIN; an empty table answers from idle
// report runs ST_RPT_AVG, _PER, _OUT; inactive task stops at _AVG, bad slot at idle
// rst_n clears the task count, the runtime sum and the config bits; the task
// memory is not cleared, only entries below the task count are ever used
// results cannot be stalled: each result is shown for exactly one cycle
module adaptive_periodic_task_scheduler #(
    parameter int MAX_TASKS    = 16,
    parameter int RUNTIME_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  aps_pkg::aps_in_t                item,
    output logic                            result_valid,
    output aps_pkg::aps_out_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int SUM_W = RUNTIME_BITS + CNT_W;
    localparam int SMP_W = (RUNTIME_BITS > 24) ? RUNTIME_BITS : 24;
    localparam int MIX_W = RUNTIME_BITS + aps_pkg::AVG_SHIFT;

    localparam logic [RUNTIME_BITS-1:0] AVG_MAX = '1;

    // one table row per task
    typedef struct packed {
        logic                    active;
        logic [31:0]             period;
        logic [31:0]             last_start;
        logic [RUNTIME_BITS-1:0] avg;
    } ent_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_SCAN_FIN = 6'b000100,
        ST_RPT_AVG  = 6'b001000,
        ST_RPT_PER  = 6'b010000,
        ST_RPT_OUT  = 6'b100000
    } state_t;

    function automatic aps_pkg::aps_out_t make_res(
        input logic [1:0]  kind,
        input logic        acc,
        input logic [3:0]  id,
        input logic [31:0] per,
        input logic        last
    );
        aps_pkg::aps_out_t r;
        r.kind           = kind;
        r.accepted       = acc;
        r.task_id        = id;
        r.current_period = per;
        r.cpu_load       = '0;
        r.last_result    = last;
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic              adapt_reg, guard_reg;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    aps_pkg::aps_in_t  in_reg, in_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  cur_idx_reg, cur_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_id_reg, pend_id_next;
    logic [31:0]       pend_per_reg, pend_per_next;
    ent_t              ent_reg, ent_next;
    logic [RUNTIME_BITS-1:0] na_reg, na_next;
    logic              res_valid_reg, res_valid_next;
    aps_pkg::aps_out_t res_reg, res_next;

    // task memory
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    ent_t              ram_wdata, rd_ent;

    logic [15:0]       load;

    // datapath helpers
    logic              cfg_wr;
    logic              slot_bad;
    logic [31:0]       elapsed;
    logic              due;
    logic [SMP_W-1:0]  smp_ext;
    logic [RUNTIME_BITS-1:0] smp_sat;
    logic [MIX_W-1:0]  mix;
    logic [31:0]       per_adj;
    logic              mem_low;

    aps_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_ent)
    );

    aps_load #(
        .SUM_W (SUM_W)
    ) u_load (
        .clk   (clk),
        .rst_n (rst_n),
        .sum   (sum_reg),
        .load  (load)
    );

    // config port, no wait states
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {31'b0, (paddr[aps_pkg::APB_ADDR_W-1] == aps_pkg::REG_GUARD)
                            ? guard_reg : adapt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_reg <= 1'b0;
            guard_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[aps_pkg::APB_ADDR_W-1] == aps_pkg::REG_ADAPTIVE)
            begin
                adapt_reg <= pwdata[0];
            end
            else
            begin
                guard_reg <= pwdata[0];
            end
        end
    end

    // scan due test: elapsed time mod 2^32 against the period
    assign elapsed = in_reg.now_ms - rd_ent.last_start;
    assign due     = rd_ent.active && (elapsed >= rd_ent.period);

    assign slot_bad = CMP_W'(item.task_slot) >= CMP_W'(total_reg);

    // runtime sample clipped to the average width
    assign smp_ext = SMP_W'(in_reg.runtime_us);
    assign smp_sat = (smp_ext > SMP_W'(AVG_MAX)) ? AVG_MAX : RUNTIME_BITS'(smp_ext);

    // avg * 7 + sample, divided by 8 below
    assign mix = {rd_ent.avg, {aps_pkg::AVG_SHIFT{1'b0}}} - MIX_W'(rd_ent.avg)
                 + MIX_W'(smp_sat);

    // period retune from the new average in adaptive mode; the two bands never overlap
    always_comb
    begin
        per_adj = ent_reg.period;
        if (adapt_reg)
        begin
            if (na_reg > RUNTIME_BITS'(aps_pkg::AVG_HIGH))
            begin
                if (ent_reg.period > (32'hFFFF_FFFF - 32'(aps_pkg::PERIOD_GROW)))
                begin
                    per_adj = 32'hFFFF_FFFF;
                end
                else
                begin
                    per_adj = ent_reg.period + 32'(aps_pkg::PERIOD_GROW);
                end
            end
            else if (na_reg < RUNTIME_BITS'(aps_pkg::AVG_LOW)
                     && ent_reg.period > 32'(aps_pkg::PERIOD_FLOOR))
            begin
                per_adj = ent_reg.period - 32'd1;
            end
        end
    end

    assign mem_low = guard_reg
                     && ($signed(in_reg.free_memory) < 16'sd200);

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        sum_next        = sum_reg;
        in_next         = in_reg;
        rd_idx_next     = rd_idx_reg;
        cur_idx_next    = cur_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_per_next   = pend_per_reg;
        ent_next        = ent_reg;
        na_next         = na_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_idx_reg;
        ram_wdata       = rd_ent;
        ram_raddr       = rd_idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                // read issued in the accept cycle, data lands next cycle
                ram_raddr = (item.cmd == aps_pkg::CMD_REPORT) ? IDX_W'(item.task_slot)
                                                              : '0;
                if (start)
                begin
                    in_next = item;
                    case (item.cmd)
                        aps_pkg::CMD_REGISTER:
                        begin
                            res_valid_next = 1'b1;
                            if (total_reg == CNT_W'(MAX_TASKS))
                            begin
                                // table full
                                res_next = make_res(aps_pkg::KIND_REGISTER, 1'b0, 4'd0,
                                                    32'd0, 1'b1);
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                ram_waddr            = total_reg[IDX_W-1:0];
                                ram_wdata.active     = 1'b1;
                                ram_wdata.period     = item.init_period;
                                ram_wdata.last_start = item.now_ms;
                                ram_wdata.avg        = '0;
                                total_next           = total_reg + CNT_W'(1);
                                res_next = make_res(aps_pkg::KIND_REGISTER, 1'b1,
                                                    4'(total_reg), item.init_period, 1'b1);
                            end
                        end
                        aps_pkg::CMD_SCAN:
                        begin
                            if (total_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_res(aps_pkg::KIND_NONE, 1'b0, 4'd0,
                                                    32'd0, 1'b1);
                            end
                            else
                            begin
                                rd_idx_next     = CNT_W'(1);
                                cur_idx_next    = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        aps_pkg::CMD_REPORT:
                        begin
                            if (slot_bad)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_res(aps_pkg::KIND_REPORT, 1'b0,
                                                    item.task_slot, 32'd0, 1'b1);
                            end
                            else
                            begin
                                state_next = ST_RPT_AVG;
                            end
                        end
                        default:
                        begin
                            // unused command code, dropped without a result
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // rd_ent holds entry cur_idx, next read already in flight
                if (due)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = cur_idx_reg;
                    ram_wdata.last_start = in_reg.now_ms;
                    // a held dispatch goes out once another one follows it
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next = make_res(aps_pkg::KIND_DISPATCH, 1'b1, 4'(pend_id_reg),
                                            pend_per_reg, 1'b0);
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = cur_idx_reg;
                    pend_per_next   = rd_ent.period;
                end
                if (rd_idx_reg == total_reg)
                begin
                    state_next = ST_SCAN_FIN;
                end
                else
                begin
                    cur_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
            end

            ST_SCAN_FIN:
            begin
                res_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    res_next = make_res(aps_pkg::KIND_DISPATCH, 1'b1, 4'(pend_id_reg),
                                        pend_per_reg, 1'b1);
                end
                else
                begin
                    res_next = make_res(aps_pkg::KIND_NONE, 1'b0, 4'd0, 32'd0, 1'b1);
                end
                state_next = ST_IDLE;
            end

            ST_RPT_AVG:
            begin
                ent_next = rd_ent;
                if (!rd_ent.active)
                begin
                    res_valid_next = 1'b1;
                    res_next = make_res(aps_pkg::KIND_REPORT, 1'b0, in_reg.task_slot,
                                        rd_ent.period, 1'b1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (!adapt_reg)
                    begin
                        na_next = rd_ent.avg;
                    end
                    else if (rd_ent.avg == '0)
                    begin
                        // first sample taken as is
                        na_next = smp_sat;
                    end
                    else
                    begin
                        na_next = mix[MIX_W-1:aps_pkg::AVG_SHIFT];
                    end
                    state_next = ST_RPT_PER;
                end
            end

            ST_RPT_PER:
            begin
                if (adapt_reg)
                begin
                    sum_next = sum_reg - SUM_W'(ent_reg.avg) + SUM_W'(na_reg);
                end
                ram_we               = 1'b1;
                ram_waddr            = IDX_W'(in_reg.task_slot);
                ram_wdata.active     = ent_reg.active && !mem_low;
                ram_wdata.period     = per_adj;
                ram_wdata.last_start = ent_reg.last_start;
                ram_wdata.avg        = na_reg;
                res_next = make_res(aps_pkg::KIND_REPORT, 1'b1, in_reg.task_slot,
                                    per_adj, 1'b1);
                state_next = ST_RPT_OUT;
            end

            ST_RPT_OUT:
            begin
                // load unit catches up with the new sum on this edge
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            sum_reg        <= '0;
            rd_idx_reg     <= '0;
            cur_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            sum_reg        <= sum_next;
            rd_idx_reg     <= rd_idx_next;
            cur_idx_reg    <= cur_idx_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        pend_id_reg  <= pend_id_next;
        pend_per_reg <= pend_per_next;
        ent_reg      <= ent_next;
        na_reg       <= na_next;
        res_reg      <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;

    always_comb
    begin
        result          = res_reg;
        result.cpu_load = load;
    end

endmodule

>>> hdl/aps_ram.sv
module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/aps_load.sv
module aps_load #(
    parameter int SUM_W = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SUM_W-1:0] sum,
    output logic [15:0]      load
);

    localparam int CW = (SUM_W > aps_pkg::LOAD_IN_W) ? SUM_W : aps_pkg::LOAD_IN_W;
    localparam int PW = 2 * aps_pkg::LOAD_IN_W;

    logic [CW-1:0]                   sum_ext;
    logic                            sat;
    logic [aps_pkg::LOAD_IN_W-1:0]   sum_lo;
    logic [PW-1:0]                   prod;
    logic [15:0]                     load_next;
    logic [15:0]                     load_reg;

    assign sum_ext = CW'(sum);
    assign sat     = sum_ext >= CW'(aps_pkg::LOAD_SAT_SUM);
    assign sum_lo  = aps_pkg::LOAD_IN_W'(sum_ext);
    assign prod    = PW'(sum_lo) * PW'(aps_pkg::RECIP_TEN);

    // saturate above 65535 * 10
    assign load_next = sat ? 16'hFFFF
                           : prod[aps_pkg::RECIP_SHIFT+15:aps_pkg::RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
        end
        else
        begin
            load_reg <= load_next;
        end
    end

    assign load = load_reg;

endmodule

>>> hdl/aps_chk.sv
`include "adaptive_periodic_task_scheduler_macros.svh"

module aps_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input aps_pkg::aps_in_t                item,
    input logic                            result_valid,
    input aps_pkg::aps_out_t               result,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [aps_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [31:0]                     pwdata,
    input logic [31:0]                     prdata,
    input logic                            pready
);

    logic scan_take;
    logic cfg_seen;

    assign scan_take = start && !busy && (item.cmd == aps_pkg::CMD_SCAN);
    assign cfg_seen  = psel && penable && pwrite && pready && (paddr != '0)
                       && (pwdata != '0) && (prdata != '0);

    // a scan transaction walks the table, or answers at once when it is empty
    `APS_ASSERT_NXT(a_scan_busy, clk, rst_n, scan_take, busy || result_valid, "scan did not start")
    // more results of a transaction pending keeps the block busy
    `APS_ASSERT_IMP(a_more_busy, clk, rst_n, result_valid && !result.last_result, busy,
        "non-final result while idle")
    // an idle block with no new transaction shows no result
    `APS_ASSERT_NXT(a_no_spurious, clk, rst_n, !busy && !start && !cfg_seen, !result_valid,
        "result without a transaction")
    // dispatches are always accepted, nothing-due never is
    `APS_ASSERT_IMP(a_kind_acc, clk, rst_n, result_valid,
        (result.kind != aps_pkg::KIND_DISPATCH || result.accepted)
        && (result.kind != aps_pkg::KIND_NONE || !result.accepted),
        "accepted flag does not match result kind")

endmodule

bind adaptive_periodic_task_scheduler aps_chk u_aps_chk (.*);
